// ===== sv/angle_between_3d_vectors_defines.svh =====
// Assertion macros shared by the angle between 3D vectors block.
`ifndef ANGLE_BETWEEN_3D_VECTORS_DEFINES_SVH
`define ANGLE_BETWEEN_3D_VECTORS_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ABV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ABV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/abv_pkg.sv =====
// Package with widths, constants and types of the angle between 3D vectors block.
`default_nettype none
package abv_pkg;
	localparam int CW = 16;
	localparam int AFB = 14;
	localparam int ANGLE_W = AFB + 2;
	localparam int PROD_W = 2 * CW;
	localparam int SUM_W = 2 * CW + 1;
	localparam int MAG_W = 2 * CW;
	localparam int NB_W = $clog2(MAG_W + 1);
	localparam int NORM_W = 31;
	localparam int SQ_W = 2 * NORM_W;
	localparam int C2_W = 64;
	localparam int ROOT_W = 32;
	localparam int SQRT_STEPS = 32;
	localparam int XY_W = 44;
	localparam int Z_W = 64;
	localparam int CORDIC_STEPS = 40;
	localparam int Q_SHIFT = 60 - AFB;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
	localparam logic [63:0] QUARTER_PI_Q60 = 64'h0C90FDAA22168C23;
	localparam logic [63:0] ROUND_Q60 = 64'd1 << (Q_SHIFT - 1);
	localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'((PI_Q60 + ROUND_Q60) >> Q_SHIFT);

	// Information that travels beside the magnitudes down the pipeline.
	typedef struct packed {
		logic zero_vec;
		logic kill;
		logic neg;
		logic [NORM_W-1:0] m3;
	} side_t;

	// Division of one series term by the odd number 2k+1.
	function automatic logic [63:0] div_odd(input logic [63:0] v, input int k);
		logic [63:0] t;
		case (k)
			0: t = v;
			1: t = v / 64'd3;
			2: t = v / 64'd5;
			3: t = v / 64'd7;
			4: t = v / 64'd9;
			5: t = v / 64'd11;
			6: t = v / 64'd13;
			7: t = v / 64'd15;
			8: t = v / 64'd17;
			9: t = v / 64'd19;
			10: t = v / 64'd21;
			11: t = v / 64'd23;
			12: t = v / 64'd25;
			13: t = v / 64'd27;
			14: t = v / 64'd29;
			15: t = v / 64'd31;
			16: t = v / 64'd33;
			17: t = v / 64'd35;
			18: t = v / 64'd37;
			19: t = v / 64'd39;
			20: t = v / 64'd41;
			21: t = v / 64'd43;
			22: t = v / 64'd45;
			23: t = v / 64'd47;
			24: t = v / 64'd49;
			25: t = v / 64'd51;
			26: t = v / 64'd53;
			27: t = v / 64'd55;
			28: t = v / 64'd57;
			29: t = v / 64'd59;
			default: t = 64'd0;
		endcase
		return t;
	endfunction

	// atan(2^-i) in Q60, a truncated Taylor series for i > 0 and pi/4 for i = 0; evaluated at elaboration.
	function automatic logic [63:0] atan_pow2(input int i);
		logic [63:0] sum;
		logic [63:0] v;
		int sh;
		sum = 64'd0;
		if (i == 0) begin
			sum = QUARTER_PI_Q60;
		end else begin
			for (int k = 0; k < 30; k++) begin
				sh = i * (2 * k + 1);
				if (sh <= 60) begin
					v = (64'd1 << 60) >> sh;
					if (k % 2 == 1) begin
						sum = sum - div_odd(v, k);
					end else begin
						sum = sum + div_odd(v, k);
					end
				end
			end
		end
		return sum;
	endfunction
endpackage
`default_nettype wire

// ===== sv/abv_ifs.sv =====
// Valid/ready channel interfaces for the vector pair input and the angle result.
`default_nettype none
interface abv_in_if;
	import abv_pkg::*;
	logic valid;
	logic ready;
	logic signed [CW-1:0] ax;
	logic signed [CW-1:0] ay;
	logic signed [CW-1:0] az;
	logic signed [CW-1:0] bx;
	logic signed [CW-1:0] by;
	logic signed [CW-1:0] bz;
	modport source(output valid, ax, ay, az, bx, by, bz, input ready);
	modport sink(input valid, ax, ay, az, bx, by, bz, output ready);
endinterface

interface abv_out_if;
	import abv_pkg::*;
	logic valid;
	logic ready;
	logic [ANGLE_W-1:0] angle;
	logic zero_vector;
	modport source(output valid, angle, zero_vector, input ready);
	modport sink(input valid, angle, zero_vector, output ready);
endinterface
`default_nettype wire

// ===== sv/abv_front.sv =====
// Front stages: products, cross and dot sums, normalization and sum of squares.
`default_nettype none
module abv_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vin,
	input wire logic signed [abv_pkg::CW-1:0] ax,
	input wire logic signed [abv_pkg::CW-1:0] ay,
	input wire logic signed [abv_pkg::CW-1:0] az,
	input wire logic signed [abv_pkg::CW-1:0] bx,
	input wire logic signed [abv_pkg::CW-1:0] by,
	input wire logic signed [abv_pkg::CW-1:0] bz,
	output logic vout,
	output logic [abv_pkg::C2_W-1:0] c2,
	output abv_pkg::side_t side
);
	import abv_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [PROD_W-1:0] p_s1 [9];
	logic zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
	logic [MAG_W-1:0] m_s2 [4];
	logic neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [MAG_W-1:0] m_s3 [4];
	logic [NB_W-1:0] nb_s3;
	logic [NORM_W-1:0] m_s4 [4];
	logic kill_s4, kill_s5, kill_s6;
	logic [SQ_W-1:0] sq_s5 [3];
	logic [NORM_W-1:0] m3_s5, m3_s6;
	logic [C2_W-1:0] c2_s6;

	logic signed [SUM_W-1:0] cx, cy, cz, dd;
	logic [MAG_W-1:0] mag_c [4];
	logic [MAG_W-1:0] orall;
	logic [NB_W-1:0] nb_c;
	logic [NORM_W-1:0] norm_c [4];
	logic [MAG_W+NORM_W-1:0] wide;

	always_comb begin
		cx = SUM_W'(p_s1[0]) - SUM_W'(p_s1[1]);
		cy = SUM_W'(p_s1[2]) - SUM_W'(p_s1[3]);
		cz = SUM_W'(p_s1[4]) - SUM_W'(p_s1[5]);
		dd = SUM_W'(p_s1[6]) + SUM_W'(p_s1[7]) + SUM_W'(p_s1[8]);
		mag_c[0] = MAG_W'(cx[SUM_W-1] ? -cx : cx);
		mag_c[1] = MAG_W'(cy[SUM_W-1] ? -cy : cy);
		mag_c[2] = MAG_W'(cz[SUM_W-1] ? -cz : cz);
		mag_c[3] = MAG_W'(dd[SUM_W-1] ? -dd : dd);
	end

	// The bit length of the largest magnitude equals that of their OR.
	always_comb begin
		orall = m_s2[0] | m_s2[1] | m_s2[2] | m_s2[3];
		nb_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (orall[b]) begin
				nb_c = NB_W'(b + 1);
			end
		end
	end

	always_comb begin
		wide = '0;
		for (int i = 0; i < 4; i++) begin
			if (nb_s3 > NB_W'(NORM_W)) begin
				wide = {{NORM_W{1'b0}}, m_s3[i]} >> (nb_s3 - NB_W'(NORM_W));
			end else begin
				wide = {{NORM_W{1'b0}}, m_s3[i]} << (NB_W'(NORM_W) - nb_s3);
			end
			norm_c[i] = wide[NORM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= vin;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= ay * bz;
			p_s1[1] <= az * by;
			p_s1[2] <= az * bx;
			p_s1[3] <= ax * bz;
			p_s1[4] <= ax * by;
			p_s1[5] <= ay * bx;
			p_s1[6] <= ax * bx;
			p_s1[7] <= ay * by;
			p_s1[8] <= az * bz;
			zero_s1 <= ((ax == '0) && (ay == '0) && (az == '0)) ||
				((bx == '0) && (by == '0) && (bz == '0));

			m_s2 <= mag_c;
			neg_s2 <= dd[SUM_W-1];
			zero_s2 <= zero_s1;

			m_s3 <= m_s2;
			nb_s3 <= nb_c;
			neg_s3 <= neg_s2;
			zero_s3 <= zero_s2;

			m_s4 <= norm_c;
			kill_s4 <= zero_s3 || (nb_s3 == '0);
			neg_s4 <= neg_s3;
			zero_s4 <= zero_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= SQ_W'(m_s4[i]) * SQ_W'(m_s4[i]);
			end
			m3_s5 <= m_s4[3];
			kill_s5 <= kill_s4;
			neg_s5 <= neg_s4;
			zero_s5 <= zero_s4;

			c2_s6 <= C2_W'(sq_s5[0]) + C2_W'(sq_s5[1]) + C2_W'(sq_s5[2]);
			m3_s6 <= m3_s5;
			kill_s6 <= kill_s5;
			neg_s6 <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	assign vout = v_s6;
	assign c2 = c2_s6;
	assign side = '{zero_vec: zero_s6, kill: kill_s6, neg: neg_s6, m3: m3_s6};
endmodule
`default_nettype wire

// ===== sv/abv_isqrt.sv =====
// Pipelined floor integer square root, one result bit per stage.
`default_nettype none
module abv_isqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vin,
	input wire logic [abv_pkg::C2_W-1:0] c2,
	input wire abv_pkg::side_t side_in,
	output logic vout,
	output logic [abv_pkg::ROOT_W-1:0] root,
	output abv_pkg::side_t side_out
);
	import abv_pkg::*;

	logic v_s [SQRT_STEPS+1];
	logic [C2_W-1:0] n_s [SQRT_STEPS+1];
	logic [C2_W-1:0] r_s [SQRT_STEPS+1];
	side_t sd_s [SQRT_STEPS+1];

	assign v_s[0] = vin;
	assign n_s[0] = c2;
	assign r_s[0] = '0;
	assign sd_s[0] = side_in;

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [C2_W-1:0] BIT = C2_W'(1) << (C2_W - 2 - 2 * j);
		logic [C2_W-1:0] trial;
		logic [C2_W-1:0] n_nx, r_nx;

		always_comb begin
			trial = r_s[j] + BIT;
			if (n_s[j] >= trial) begin
				n_nx = n_s[j] - trial;
				r_nx = (r_s[j] >> 1) + BIT;
			end else begin
				n_nx = n_s[j];
				r_nx = r_s[j] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[j+1] <= n_nx;
				r_s[j+1] <= r_nx;
				sd_s[j+1] <= sd_s[j];
			end
		end
	end

	assign vout = v_s[SQRT_STEPS];
	assign root = r_s[SQRT_STEPS][ROOT_W-1:0];
	assign side_out = sd_s[SQRT_STEPS];
endmodule
`default_nettype wire

// ===== sv/abv_cordic.sv =====
// Pipelined vectoring CORDIC for atan2, then clamp, reflection and rounding.
`default_nettype none
module abv_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic vin,
	input wire logic [abv_pkg::ROOT_W-1:0] root,
	input wire abv_pkg::side_t side_in,
	output logic vout,
	output logic [abv_pkg::ANGLE_W-1:0] angle,
	output logic zero_vector
);
	import abv_pkg::*;

	logic v_s [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XY_W-1:0] y_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0] z_s [CORDIC_STEPS+1];
	side_t sd_s [CORDIC_STEPS+1];
	logic vf_s;
	logic [ANGLE_W-1:0] ang_s;
	logic zv_s;

	logic [63:0] ang_c, q_c;

	assign v_s[0] = vin;
	assign x_s[0] = XY_W'(side_in.m3) << 8;
	assign y_s[0] = XY_W'(root) << 8;
	assign z_s[0] = '0;
	assign sd_s[0] = side_in;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
		localparam logic signed [Z_W-1:0] ATAN_I = Z_W'(atan_pow2(i));
		logic signed [XY_W-1:0] xs, ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!y_s[i][XY_W-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATAN_I;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATAN_I;
				end
				sd_s[i+1] <= sd_s[i];
			end
		end
	end

	// Keep the accumulated angle in the first quadrant before reflecting it.
	always_comb begin
		if (z_s[CORDIC_STEPS][Z_W-1]) begin
			ang_c = '0;
		end else if (64'(z_s[CORDIC_STEPS]) > HALF_PI_Q60) begin
			ang_c = HALF_PI_Q60;
		end else begin
			ang_c = 64'(z_s[CORDIC_STEPS]);
		end
		if (sd_s[CORDIC_STEPS].neg) begin
			ang_c = PI_Q60 - ang_c;
		end
		q_c = (ang_c + ROUND_Q60) >> Q_SHIFT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_s <= 1'b0;
		end else if (en) begin
			vf_s <= v_s[CORDIC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s <= sd_s[CORDIC_STEPS].kill ? '0 : q_c[ANGLE_W-1:0];
			zv_s <= sd_s[CORDIC_STEPS].zero_vec;
		end
	end

	assign vout = vf_s;
	assign angle = ang_s;
	assign zero_vector = zv_s;
endmodule
`default_nettype wire

// ===== sv/angle_between_3d_vectors.sv =====
// Throughput: one pair per cycle unless the output stalls; the pipeline advances as one whole.
// Depth is set by 6 front stages, 32 square root stages, 40 CORDIC stages and one output stage.
// A stalled output freezes every stage, so no item is lost or repeated.
// Reset (arst_n low) clears all valid bits at once; the data registers are not reset.
`default_nettype none
`include "angle_between_3d_vectors_defines.svh"
module angle_between_3d_vectors (
	input wire logic clk,
	input wire logic arst_n,
	abv_in_if.sink in_ch,
	abv_out_if.source out_ch
);
	import abv_pkg::*;

	logic en;
	logic fr_v, sq_v, co_v;
	logic [C2_W-1:0] fr_c2;
	side_t fr_side, sq_side;
	logic [ROOT_W-1:0] sq_root;

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	abv_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vin(in_ch.valid),
		.ax(in_ch.ax),
		.ay(in_ch.ay),
		.az(in_ch.az),
		.bx(in_ch.bx),
		.by(in_ch.by),
		.bz(in_ch.bz),
		.vout(fr_v),
		.c2(fr_c2),
		.side(fr_side)
	);

	abv_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vin(fr_v),
		.c2(fr_c2),
		.side_in(fr_side),
		.vout(sq_v),
		.root(sq_root),
		.side_out(sq_side)
	);

	abv_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.vin(sq_v),
		.root(sq_root),
		.side_in(sq_side),
		.vout(co_v),
		.angle(out_ch.angle),
		.zero_vector(out_ch.zero_vector)
	);

	assign out_ch.valid = co_v;

	`ABV_ASSERT_NOW(a_zero_angle, out_ch.valid && out_ch.zero_vector, out_ch.angle == '0, "zero vector with nonzero angle")
	`ABV_ASSERT_NOW(a_angle_range, out_ch.valid, out_ch.angle <= ANGLE_MAX, "angle above pi")
	`ABV_ASSERT_NEXT(a_stall_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.angle), "stalled result changed")
endmodule
`default_nettype wire

// ===== tb/sv/abv_tb_ifs.sv =====
// Testbench types for one vector pair and one expected angle result.
`default_nettype none
package abv_tb_types;
	import abv_pkg::*;
	// One vector pair as driven on the input channel.
	typedef struct packed {
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		logic signed [CW-1:0] az;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic signed [CW-1:0] bz;
	} vec_pair_t;

	// One angle result as expected on the output channel.
	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic zero_vector;
	} angle_res_t;
endpackage
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the angle between 3D vectors pipeline.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import abv_pkg::*;
	import abv_tb_types::*;

	localparam int LATENCY = 79;

	// Independent fixed-point predictor: exact products, normalization, integer
	// square root, then a vectoring CORDIC on (dot, |cross|).
	class angle_scoreboard;
		angle_res_t pending[$];
		int mismatches;
		int checked;
		int zero_cases;
		int obtuse_cases;
		logic [63:0] atan_tab[CORDIC_STEPS];

		function new();
			logic [63:0] acc;
			logic [63:0] t;
			int sh;
			mismatches = 0;
			checked = 0;
			zero_cases = 0;
			obtuse_cases = 0;
			atan_tab[0] = QUARTER_PI_Q60;
			for (int i = 1; i < CORDIC_STEPS; i++) begin
				acc = 64'd0;
				for (int k = 0; k < 64; k++) begin
					sh = i * (2 * k + 1);
					if (sh > 60) break;
					t = ((64'd1 << 60) >> sh) / (2 * k + 1);
					if (k % 2 == 1) acc = acc - t;
					else acc = acc + t;
				end
				atan_tab[i] = acc;
			end
		endfunction

		function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
			logic [63:0] r;
			logic [63:0] b;
			r = '0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n = n - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function automatic angle_res_t predict_angle(input vec_pair_t p);
			longint ax, ay, az, bx, by, bz, cx, cy, cz, d, x, y, z, xs, ys;
			logic [63:0] m[4];
			logic [63:0] top, c2, cm, ang;
			int nb;
			angle_res_t r;
			ax = p.ax; ay = p.ay; az = p.az;
			bx = p.bx; by = p.by; bz = p.bz;
			r.angle = '0;
			r.zero_vector = 1'b0;
			if ((ax == 0 && ay == 0 && az == 0) || (bx == 0 && by == 0 && bz == 0)) begin
				r.zero_vector = 1'b1;
				return r;
			end
			cx = ay * bz - az * by;
			cy = az * bx - ax * bz;
			cz = ax * by - ay * bx;
			d = ax * bx + ay * by + az * bz;
			m[0] = cx < 0 ? -cx : cx;
			m[1] = cy < 0 ? -cy : cy;
			m[2] = cz < 0 ? -cz : cz;
			m[3] = d < 0 ? -d : d;
			top = '0;
			for (int i = 0; i < 4; i++) if (m[i] > top) top = m[i];
			if (top == 0) return r;
			nb = 0;
			while ((top >> nb) != 0) nb++;
			for (int i = 0; i < 4; i++) begin
				if (nb > 31) m[i] = m[i] >> (nb - 31);
				else m[i] = m[i] << (31 - nb);
			end
			c2 = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			cm = floor_sqrt(c2);
			x = longint'(m[3] << 8);
			y = longint'(cm << 8);
			z = 0;
			for (int i = 0; i < CORDIC_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + longint'(atan_tab[i]);
				end else begin
					x = x - ys; y = y + xs; z = z - longint'(atan_tab[i]);
				end
			end
			if (z < 0) ang = '0;
			else if (64'(z) > HALF_PI_Q60) ang = HALF_PI_Q60;
			else ang = 64'(z);
			if (d < 0) ang = PI_Q60 - ang;
			r.angle = ANGLE_W'((ang + ROUND_Q60) >> Q_SHIFT);
			return r;
		endfunction

		function void note_pair(input vec_pair_t p);
			angle_res_t r;
			r = predict_angle(p);
			if (r.zero_vector) zero_cases++;
			if (r.angle > (ANGLE_MAX >> 1) + 1) obtuse_cases++;
			pending.push_back(r);
		endfunction

		function void check_result(input angle_res_t got);
			angle_res_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: angle=%0d zero_vector=%0b",
						got.angle, got.zero_vector);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.angle !== want.angle || got.zero_vector !== want.zero_vector) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Mismatch on result %0d: angle exp %0d got %0d, zero_vector exp %0b got %0b",
						checked, want.angle, got.angle, want.zero_vector, got.zero_vector);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	abv_in_if in_ch ();
	abv_out_if out_ch ();

	angle_between_3d_vectors u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	angle_scoreboard sb;
	bit stim_done;
	int sent;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d results outstanding", sb.pending.size());
		$display("Regression FAIL");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(0, 5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return CW'($urandom_range(0, 6)) - 16'sd3;
			default: return CW'($urandom);
		endcase
	endfunction

	task automatic send_pair(input vec_pair_t p);
		in_ch.valid <= 1'b1;
		{in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz} <= p;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		sb.note_pair(p);
		sent++;
	endtask

	task automatic send_with_gap(input vec_pair_t p);
		int gap;
		send_pair(p);
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic vec_pair_t make_pair(input int kind);
		vec_pair_t p;
		logic signed [CW-1:0] k;
		p = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord()};
		case (kind)
			0: begin
				// Parallel or antiparallel: b is a small multiple of a.
				p.ax = CW'($signed($urandom_range(0, 400)) - 200);
				p.ay = CW'($signed($urandom_range(0, 400)) - 200);
				p.az = CW'($signed($urandom_range(0, 400)) - 200);
				k = CW'($signed($urandom_range(0, 20)) - 10);
				p.bx = p.ax * k; p.by = p.ay * k; p.bz = p.az * k;
			end
			1: begin
				// Perpendicular: b = (-ay, ax, 0).
				p.bx = -p.ay; p.by = p.ax; p.bz = '0;
			end
			2: begin
				// Nearly parallel.
				p.bx = p.ax + CW'($urandom_range(0, 2)) - CW'(1);
				p.by = p.ay;
				p.bz = p.az - CW'($urandom_range(0, 2)) + CW'(1);
			end
			3: {p.ax, p.ay, p.az} = '0;
			default: ;
		endcase
		return p;
	endfunction

	initial begin
		vec_pair_t dir[$];
		vec_pair_t p;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		{in_ch.ax, in_ch.ay, in_ch.az, in_ch.bx, in_ch.by, in_ch.bz} = '0;
		sb = new();
		stim_done = 1'b0;
		sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0});
		dir.push_back({16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0});
		dir.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0});
		dir.push_back({16'sd0, 16'sd0, 16'sd0, 16'sd5, 16'sd6, 16'sd7});
		dir.push_back({16'sd5, 16'sd6, 16'sd7, 16'sd0, 16'sd0, 16'sd0});
		dir.push_back({96'd0});
		dir.push_back({-16'sd32768, -16'sd32768, -16'sd32768,
			-16'sd32768, -16'sd32768, -16'sd32768});
		dir.push_back({-16'sd32768, -16'sd32768, -16'sd32768,
			16'sd32767, 16'sd32767, 16'sd32767});
		dir.push_back({16'sd32767, 16'sd32767, 16'sd32767,
			16'sd32767, 16'sd32767, 16'sd32767});
		dir.push_back({16'sd32767, -16'sd32768, 16'sd0, 16'sd32767, 16'sd32767, 16'sd0});
		dir.push_back({16'sd1, 16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd2});
		dir.push_back({16'sd32767, 16'sd1, 16'sd0, 16'sd32767, 16'sd0, 16'sd0});
		dir.push_back({16'sd32767, 16'sd1, 16'sd0, -16'sd32767, 16'sd0, 16'sd0});
		dir.push_back({16'sd3, 16'sd4, 16'sd0, -16'sd4, 16'sd3, 16'sd0});
		dir.push_back({-16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1});
		dir.push_back({16'sd2, 16'sd4, 16'sd6, -16'sd1, -16'sd2, -16'sd3});
		dir.push_back({16'sd1, 16'sd2, 16'sd3, 16'sd1, 16'sd2, 16'sd4});
		foreach (dir[i]) send_with_gap(dir[i]);

		for (int n = 0; n < 640; n++) begin
			p = make_pair($urandom_range(0, 9));
			// Once mid-run, hold off until the pipeline has drained.
			if (n == 300) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (sb.pending.size() != 0) @(posedge clk);
			end
			// A stretch without gaps keeps the pipeline full.
			if (n >= 100 && n < 180) send_pair(p);
			else send_with_gap(p);
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Result side: random stalls, with a stretch of constant readiness.
	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				sb.check_result({out_ch.angle, out_ch.zero_vector});
			if (sb.checked > 150 && sb.checked < 250) begin
				out_ch.ready <= 1'b1;
			end else begin
				gap = pick_gap();
				out_ch.ready <= (gap == 0) || ($urandom_range(0, gap) == 0);
			end
		end
	end

	initial begin
		int waited;
		@(posedge arst_n);
		wait (stim_done);
		waited = 0;
		while (sb.pending.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 20) @(posedge clk);
		if (sb.pending.size() != 0) sb.mismatches++;
		$display("Sent %0d vector pairs, checked %0d angles (%0d with a zero vector, %0d obtuse).",
			sent, sb.checked, sb.zero_cases, sb.obtuse_cases);
		$display("Mismatches: %0d, results never delivered: %0d.",
			sb.mismatches, sb.pending.size());
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
`default_nettype wire
